// ----- src/dsa_pkg.sv -----
// shared types and constants of the descriptor slot allocator
`default_nettype none

package dsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int COUNT_W   = SLOT_W + 1;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 12;
    localparam int ADDR_W   = 64;
    localparam int STATUS_W = 3;

    localparam int CAP_W    = 11;
    localparam int STRIDE_W = 13;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;

    // quotient bits resolved per divider cycle
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = ADDR_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] MAX_SLOTS_C = COUNT_W'(MAX_SLOTS);

    localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(1024);
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

    localparam logic [OP_W-1:0] OP_ALLOC       = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE_INDEX  = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE_HANDLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_EXHAUSTED = 3'd1,
        STATUS_RANGE     = 3'd2,
        STATUS_DOUBLE    = 3'd3,
        STATUS_MISALIGN  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_LOOKUP,
        ST_ALLOC_RD,
        ST_FREE_RD,
        ST_REPLY
    } state_t;

endpackage

`default_nettype wire

// ----- src/descriptor_slot_allocator.sv -----
// descriptor slot allocator: free stack, bump pointer and in-use bitmap in block memories
//
// s_axis carries one request word (allocate, free by slot index, free by handle
// address); m_axis returns exactly one reply word per request, in order.
// cfg_we/cfg_index/cfg_wdata write capacity, stride and heap base; the user must do so
// only while idle, since the block does not enforce it. One request is worked at a time:
//   allocate          one free-stack read when the stack is not empty
//   free by index     one bitmap read, then write-back and stack push
//   free by handle    the divider, which resolves four quotient bits of offset / stride
//                     per cycle, then the lookup and bitmap read of free by index
// The next request is taken in the cycle after the previous reply is loaded into the
// output register, even while the receiver has not taken it yet. If the receiver stalls,
// the next reply waits in the reply state and s_axis_tready stays low.
// Reset clears the stack count and the bump pointer and sets the configuration to its
// reset values; the bitmap needs no clearing pass since entries at or above the bump
// pointer read as free. Each request finishes its memory writes before the next one reads.
`default_nettype none

module descriptor_slot_allocator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // operation[1:0], slot_index[13:2], handle_address[77:14], zero pad
    input  wire logic [dsa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // granted_index[9:0], status[12:10], zero pad
    output logic [dsa_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              cfg_we,
    input  wire logic [dsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dsa_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int SLOT_W   = dsa_pkg::SLOT_W;
    localparam int COUNT_W  = dsa_pkg::COUNT_W;
    localparam int ADDR_W   = dsa_pkg::ADDR_W;
    localparam int IDX_W    = dsa_pkg::IDX_W;
    localparam int STRIDE_W = dsa_pkg::STRIDE_W;

    // configuration
    logic [dsa_pkg::CAP_W-1:0] cap_reg;
    logic [STRIDE_W-1:0]       stride_reg;
    logic [ADDR_W-1:0]         base_reg;

    // control
    dsa_pkg::state_t state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] fresh_reg, fresh_next;
    logic [dsa_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic out_valid_reg, out_valid_next;

    // payload
    logic [dsa_pkg::OP_W-1:0] op_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [ADDR_W-1:0]        hdl_reg;
    logic [ADDR_W-1:0]        div_reg, div_next;
    logic [STRIDE_W-1:0]      rem_reg, rem_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [SLOT_W-1:0]        res_index_reg, res_index_next;
    dsa_pkg::status_t         res_status_reg, res_status_next;
    logic [SLOT_W-1:0]        out_index_reg, out_index_next;
    dsa_pkg::status_t         out_status_reg, out_status_next;

    // memories
    logic [SLOT_W-1:0] free_stack_mem [dsa_pkg::MAX_SLOTS];
    logic              in_use_mem [dsa_pkg::MAX_SLOTS];
    logic [SLOT_W-1:0] stack_rd_reg;
    logic              in_use_rd_reg;

    logic              stack_we;
    logic [SLOT_W-1:0] stack_waddr;
    logic [SLOT_W-1:0] stack_wdata;
    logic [SLOT_W-1:0] stack_raddr;
    logic              in_use_we;
    logic [SLOT_W-1:0] in_use_waddr;
    logic              in_use_wdata;
    logic [SLOT_W-1:0] in_use_raddr;

    logic                   in_accept;
    logic [COUNT_W-1:0]     eff_cap;
    logic [ADDR_W:0]        offset_diff;
    logic [ADDR_W-1:0]      div_step_q;
    logic [STRIDE_W-1:0]    div_step_r;
    logic [STRIDE_W:0]      div_trial;
    logic [ADDR_W-1:0]      cand;
    logic                   cand_range;
    logic                   slot_used;

    assign s_axis_tready = (state_reg == dsa_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(dsa_pkg::OUT_DATA_W - SLOT_W - dsa_pkg::STATUS_W){1'b0}},
                            out_status_reg, out_index_reg};

    assign eff_cap = (COUNT_W'(cap_reg) > dsa_pkg::MAX_SLOTS_C) ? dsa_pkg::MAX_SLOTS_C
                                                                 : COUNT_W'(cap_reg);

    // a borrow out of the subtraction means the handle lies below the base
    assign offset_diff = {1'b0, hdl_reg} - {1'b0, base_reg};

    assign cand = (op_reg == dsa_pkg::OP_FREE_HANDLE) ? div_reg
                                                      : {{(ADDR_W - IDX_W){1'b0}}, idx_reg};
    assign cand_range = (cand >= {{(ADDR_W - COUNT_W){1'b0}}, eff_cap});

    // slots at or above the bump pointer were never handed out, so they read free
    assign slot_used = (COUNT_W'(slot_reg) < fresh_reg) ? in_use_rd_reg : 1'b0;

    // restoring divider, DIV_BITS quotient bits per cycle, quotient shifts into div_reg
    always_comb
    begin
        div_step_q = div_reg;
        div_step_r = rem_reg;
        div_trial  = '0;
        for (int k = 0; k < dsa_pkg::DIV_BITS; k++)
        begin
            div_trial  = {div_step_r, div_step_q[ADDR_W-1]};
            div_step_q = {div_step_q[ADDR_W-2:0], 1'b0};
            if (div_trial >= {1'b0, stride_reg})
            begin
                div_trial     = div_trial - {1'b0, stride_reg};
                div_step_q[0] = 1'b1;
            end
            div_step_r = div_trial[STRIDE_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        div_cnt_next    = div_cnt_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        slot_next       = slot_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;

        stack_we     = 1'b0;
        stack_waddr  = count_reg[SLOT_W-1:0];
        stack_wdata  = slot_reg;
        stack_raddr  = SLOT_W'(count_reg - COUNT_W'(1));
        in_use_we    = 1'b0;
        in_use_waddr = slot_reg;
        in_use_wdata = 1'b0;
        in_use_raddr = cand[SLOT_W-1:0];

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            dsa_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = dsa_pkg::ST_DECODE;
                end
            end

            dsa_pkg::ST_DECODE:
            begin
                res_index_next  = '0;
                res_status_next = dsa_pkg::STATUS_RANGE;
                state_next      = dsa_pkg::ST_REPLY;
                case (op_reg)
                    dsa_pkg::OP_ALLOC:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = dsa_pkg::ST_ALLOC_RD;
                        end
                        else if (fresh_reg >= eff_cap)
                        begin
                            res_status_next = dsa_pkg::STATUS_EXHAUSTED;
                        end
                        else
                        begin
                            in_use_we       = 1'b1;
                            in_use_waddr    = fresh_reg[SLOT_W-1:0];
                            in_use_wdata    = 1'b1;
                            res_index_next  = fresh_reg[SLOT_W-1:0];
                            res_status_next = dsa_pkg::STATUS_OK;
                            fresh_next      = fresh_reg + COUNT_W'(1);
                        end
                    end
                    dsa_pkg::OP_FREE_INDEX:
                    begin
                        state_next = dsa_pkg::ST_LOOKUP;
                    end
                    dsa_pkg::OP_FREE_HANDLE:
                    begin
                        if (!offset_diff[ADDR_W] && stride_reg != '0)
                        begin
                            div_next     = offset_diff[ADDR_W-1:0];
                            rem_next     = '0;
                            div_cnt_next = '0;
                            state_next   = dsa_pkg::ST_DIVIDE;
                        end
                    end
                    default:
                    begin
                        state_next = dsa_pkg::ST_REPLY;
                    end
                endcase
            end

            dsa_pkg::ST_DIVIDE:
            begin
                div_next     = div_step_q;
                rem_next     = div_step_r;
                div_cnt_next = div_cnt_reg + dsa_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == dsa_pkg::DIV_CNT_W'(dsa_pkg::DIV_STEPS - 1))
                begin
                    state_next = dsa_pkg::ST_LOOKUP;
                end
            end

            dsa_pkg::ST_LOOKUP:
            begin
                res_index_next = '0;
                slot_next      = cand[SLOT_W-1:0];
                // alignment is checked before range
                if (op_reg == dsa_pkg::OP_FREE_HANDLE && rem_reg != '0)
                begin
                    res_status_next = dsa_pkg::STATUS_MISALIGN;
                    state_next      = dsa_pkg::ST_REPLY;
                end
                else if (cand_range)
                begin
                    res_status_next = dsa_pkg::STATUS_RANGE;
                    state_next      = dsa_pkg::ST_REPLY;
                end
                else
                begin
                    state_next = dsa_pkg::ST_FREE_RD;
                end
            end

            dsa_pkg::ST_ALLOC_RD:
            begin
                in_use_we       = 1'b1;
                in_use_waddr    = stack_rd_reg;
                in_use_wdata    = 1'b1;
                count_next      = count_reg - COUNT_W'(1);
                res_index_next  = stack_rd_reg;
                res_status_next = dsa_pkg::STATUS_OK;
                state_next      = dsa_pkg::ST_REPLY;
            end

            dsa_pkg::ST_FREE_RD:
            begin
                state_next = dsa_pkg::ST_REPLY;
                if (!slot_used)
                begin
                    res_status_next = dsa_pkg::STATUS_DOUBLE;
                end
                else
                begin
                    res_status_next = dsa_pkg::STATUS_OK;
                    in_use_we       = 1'b1;
                    in_use_wdata    = 1'b0;
                    if (count_reg < dsa_pkg::MAX_SLOTS_C)
                    begin
                        stack_we   = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end

            dsa_pkg::ST_REPLY:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = res_index_reg;
                    out_status_next = res_status_reg;
                    state_next      = dsa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsa_pkg::ST_IDLE;
            count_reg     <= '0;
            fresh_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            cap_reg       <= dsa_pkg::CAP_RESET;
            stride_reg    <= dsa_pkg::STRIDE_RESET;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dsa_pkg::REG_CAPACITY: cap_reg    <= cfg_wdata[dsa_pkg::CAP_W-1:0];
                    dsa_pkg::REG_STRIDE:   stride_reg <= cfg_wdata[STRIDE_W-1:0];
                    dsa_pkg::REG_BASE:     base_reg   <= cfg_wdata;
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= s_axis_tdata[dsa_pkg::OP_W-1:0];
            idx_reg <= s_axis_tdata[dsa_pkg::OP_W +: IDX_W];
            hdl_reg <= s_axis_tdata[dsa_pkg::OP_W + IDX_W +: ADDR_W];
        end
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        slot_reg       <= slot_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            free_stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_rd_reg <= free_stack_mem[stack_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_use_we)
        begin
            in_use_mem[in_use_waddr] <= in_use_wdata;
        end
        in_use_rd_reg <= in_use_mem[in_use_raddr];
    end

    // the stack only holds distinct slots that were handed out by the bump pointer
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= fresh_reg)
        else $error("free stack holds more entries than slots ever handed out");

    assert property (@(posedge clk) disable iff (!rst_n) fresh_reg <= dsa_pkg::MAX_SLOTS_C)
        else $error("bump pointer ran past the slot store");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsa_pkg::ST_DIVIDE) |-> (op_reg == dsa_pkg::OP_FREE_HANDLE))
        else $error("divider running for a request that is not a handle free");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == dsa_pkg::ST_REPLY))
        else $error("reply loaded outside the reply state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsa_pkg::ST_ALLOC_RD) |-> (count_reg != '0))
        else $error("stack pop with an empty free stack");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for the descriptor slot allocator: directed and random requests checked by a scoreboard
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dsa_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;
    localparam int STALL_LIMIT      = 4000;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 215;

    typedef struct {
        logic [dsa_pkg::OP_W-1:0]   op;
        logic [dsa_pkg::IDX_W-1:0]  slot_index;
        logic [dsa_pkg::ADDR_W-1:0] handle;
    } request_t;

    typedef struct {
        logic [dsa_pkg::SLOT_W-1:0] granted;
        dsa_pkg::status_t           status;
    } reply_t;

    class slot_scoreboard;
        logic [dsa_pkg::CAP_W-1:0]    capacity;
        logic [dsa_pkg::STRIDE_W-1:0] stride;
        logic [dsa_pkg::ADDR_W-1:0]   base;
        logic [dsa_pkg::SLOT_W-1:0]   freed_slots [dsa_pkg::MAX_SLOTS];
        logic [dsa_pkg::COUNT_W-1:0]  freed_count;
        logic [dsa_pkg::COUNT_W-1:0]  fresh_slot;
        bit                           busy [dsa_pkg::MAX_SLOTS];
        reply_t                       awaited [$];
        int                           failures;
        int                           requests;
        int                           replies;
        int                           by_status [5];

        function new();
            capacity    = dsa_pkg::CAP_RESET;
            stride      = dsa_pkg::STRIDE_RESET;
            base        = '0;
            freed_count = '0;
            fresh_slot  = '0;
            foreach (busy[i]) busy[i] = 1'b0;
            foreach (by_status[i]) by_status[i] = 0;
            failures = 0;
            requests = 0;
            replies  = 0;
        endfunction

        function void set_registers(logic [dsa_pkg::CAP_W-1:0] cap,
                                    logic [dsa_pkg::STRIDE_W-1:0] strd,
                                    logic [dsa_pkg::ADDR_W-1:0] addr);
            capacity = cap;
            stride   = strd;
            base     = addr;
        endfunction

        function logic [dsa_pkg::COUNT_W-1:0] usable_slots();
            return (capacity > dsa_pkg::CAP_W'(dsa_pkg::MAX_SLOTS)) ? dsa_pkg::MAX_SLOTS_C
                                                                   : dsa_pkg::COUNT_W'(capacity);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [dsa_pkg::ADDR_W-1:0] handle_of(logic [dsa_pkg::SLOT_W-1:0] slot);
            return base + dsa_pkg::ADDR_W'(slot) * dsa_pkg::ADDR_W'(stride);
        endfunction

        // random probe for a slot that is currently handed out
        function bit pick_busy_slot(output logic [dsa_pkg::SLOT_W-1:0] slot);
            int unsigned span;
            slot = '0;
            span = 32'(fresh_slot);
            if (span == 0)
                return 1'b0;
            repeat (16)
            begin
                slot = dsa_pkg::SLOT_W'($urandom_range(span - 1));
                if (busy[slot])
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function dsa_pkg::status_t release_slot(logic [dsa_pkg::ADDR_W-1:0] slot);
            if (slot >= dsa_pkg::ADDR_W'(usable_slots()))
                return dsa_pkg::STATUS_RANGE;
            if (!busy[slot[dsa_pkg::SLOT_W-1:0]])
                return dsa_pkg::STATUS_DOUBLE;
            busy[slot[dsa_pkg::SLOT_W-1:0]] = 1'b0;
            if (freed_count < dsa_pkg::MAX_SLOTS_C)
            begin
                freed_slots[freed_count[dsa_pkg::SLOT_W-1:0]] = slot[dsa_pkg::SLOT_W-1:0];
                freed_count++;
            end
            return dsa_pkg::STATUS_OK;
        endfunction

        function void note_request(request_t req);
            reply_t                     want;
            logic [dsa_pkg::ADDR_W-1:0] offset;
            logic [dsa_pkg::SLOT_W-1:0] slot;
            want.granted = '0;
            want.status  = dsa_pkg::STATUS_RANGE;
            case (req.op)
                dsa_pkg::OP_ALLOC:
                begin
                    if (freed_count != '0)
                    begin
                        freed_count--;
                        slot = freed_slots[freed_count[dsa_pkg::SLOT_W-1:0]];
                        busy[slot]   = 1'b1;
                        want.granted = slot;
                        want.status  = dsa_pkg::STATUS_OK;
                    end
                    else if (fresh_slot >= usable_slots())
                        want.status = dsa_pkg::STATUS_EXHAUSTED;
                    else
                    begin
                        busy[fresh_slot[dsa_pkg::SLOT_W-1:0]] = 1'b1;
                        want.granted = fresh_slot[dsa_pkg::SLOT_W-1:0];
                        want.status  = dsa_pkg::STATUS_OK;
                        fresh_slot++;
                    end
                end
                dsa_pkg::OP_FREE_INDEX:
                    want.status = release_slot(dsa_pkg::ADDR_W'(req.slot_index));
                dsa_pkg::OP_FREE_HANDLE:
                begin
                    if (req.handle < base || stride == '0)
                        want.status = dsa_pkg::STATUS_RANGE;
                    else
                    begin
                        offset = req.handle - base;
                        // alignment is checked before the range
                        if (offset % dsa_pkg::ADDR_W'(stride) != '0)
                            want.status = dsa_pkg::STATUS_MISALIGN;
                        else
                            want.status = release_slot(offset / dsa_pkg::ADDR_W'(stride));
                    end
                end
                default:
                    want.status = dsa_pkg::STATUS_RANGE;
            endcase
            awaited.insert(awaited.size(), want);
            requests++;
        endfunction

        function void check_reply(logic [dsa_pkg::OUT_DATA_W-1:0] word);
            reply_t                       want;
            logic [dsa_pkg::SLOT_W-1:0]   got_index;
            logic [dsa_pkg::STATUS_W-1:0] got_status;
            got_index  = word[dsa_pkg::SLOT_W-1:0];
            got_status = word[dsa_pkg::SLOT_W +: dsa_pkg::STATUS_W];
            replies++;
            if (got_status <= dsa_pkg::STATUS_MISALIGN)
                by_status[got_status]++;
            if (awaited.size() == 0)
            begin
                $error("reply word with no request waiting: granted_index %0d, status %0d",
                       got_index, got_status);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got_index !== want.granted)
            begin
                $error("granted_index: expected %0d, got %0d", want.granted, got_index);
                failures++;
            end
            if (got_status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                failures++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n         = 1'b0;
    logic [dsa_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [dsa_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [dsa_pkg::CFG_W-1:0]      cfg_wdata     = '0;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int stall_cycles       = 0;

    slot_scoreboard ledger;

    descriptor_slot_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    // reply checking and the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                ledger.check_reply(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $error("no word moved for %0d cycles", stall_cycles);
                $display("descriptor_slot_allocator: mismatch");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(request_t req);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= dsa_pkg::IN_DATA_W'({req.handle, req.slot_index, req.op});
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ledger.note_request(req);
    endtask

    task automatic issue(logic [dsa_pkg::OP_W-1:0] op, logic [dsa_pkg::IDX_W-1:0] idx,
                         logic [dsa_pkg::ADDR_W-1:0] handle);
        request_t req;
        req.op         = op;
        req.slot_index = idx;
        req.handle     = handle;
        send_request(req);
    endtask

    // stop sending and wait for every outstanding reply
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // upper bits beyond each register width are noise the block must ignore
    task automatic program_registers(logic [dsa_pkg::CAP_W-1:0] cap,
                                     logic [dsa_pkg::STRIDE_W-1:0] strd,
                                     logic [dsa_pkg::ADDR_W-1:0] addr);
        logic [dsa_pkg::CFG_W-1:0] noise;
        noise     = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= dsa_pkg::REG_CAPACITY;
        cfg_wdata <= {noise[dsa_pkg::CFG_W-1:dsa_pkg::CAP_W], cap};
        @(posedge clk);
        cfg_index <= dsa_pkg::REG_STRIDE;
        cfg_wdata <= {noise[dsa_pkg::CFG_W-1:dsa_pkg::STRIDE_W], strd};
        @(posedge clk);
        cfg_index <= dsa_pkg::REG_BASE;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        ledger.set_registers(cap, strd, addr);
    endtask

    // mostly well-formed allocate/free traffic, with some malformed frees mixed in
    task automatic random_request();
        request_t                   req;
        logic [dsa_pkg::SLOT_W-1:0] slot;
        int unsigned                pick;
        req.op         = dsa_pkg::OP_ALLOC;
        req.slot_index = dsa_pkg::IDX_W'($urandom);
        req.handle     = {$urandom, $urandom};
        pick           = $urandom_range(99);
        if (pick < 40)
            req.op = dsa_pkg::OP_ALLOC;
        else if (pick < 62)
        begin
            if (ledger.pick_busy_slot(slot))
            begin
                req.op         = dsa_pkg::OP_FREE_INDEX;
                req.slot_index = dsa_pkg::IDX_W'(slot);
            end
        end
        else if (pick < 80)
        begin
            if (ledger.pick_busy_slot(slot))
            begin
                req.op     = dsa_pkg::OP_FREE_HANDLE;
                req.handle = ledger.handle_of(slot);
            end
        end
        else if (pick < 85)
            req.op = dsa_pkg::OP_FREE_INDEX;
        else if (pick < 90)
            req.op = dsa_pkg::OP_FREE_HANDLE;
        else if (pick < 93)
        begin
            req.op = dsa_pkg::OP_FREE_HANDLE;
            if (ledger.stride > 1)
                req.handle = ledger.handle_of(dsa_pkg::SLOT_W'($urandom))
                             + dsa_pkg::ADDR_W'($urandom_range(ledger.stride - 1, 1));
        end
        else if (pick < 96)
        begin
            req.op = dsa_pkg::OP_FREE_HANDLE;
            if (ledger.base != '0)
                req.handle = req.handle % ledger.base;
        end
        else if (pick < 98)
        begin
            req.op         = dsa_pkg::OP_FREE_INDEX;
            req.slot_index = dsa_pkg::IDX_W'($urandom_range(dsa_pkg::MAX_SLOTS - 1));
        end
        else
            req.op = OP_UNDEFINED;
        send_request(req);
    endtask

    initial
    begin
        logic [dsa_pkg::CAP_W-1:0]    cap_plan    [PHASES];
        logic [dsa_pkg::STRIDE_W-1:0] stride_plan [PHASES];
        logic [dsa_pkg::ADDR_W-1:0]   base_plan   [PHASES];
        int                           idle_plan   [PHASES];

        ledger = new();
        cap_plan    = '{11'd16, 11'd0, 11'd300, 11'd1024, 11'd1, 11'd1024, 11'd700, 11'd1024};
        stride_plan = '{13'd24, 13'd1, 13'd48, 13'd4096, 13'd4095, 13'd8, 13'd1, 13'd32};
        idle_plan   = '{0, 1, 2, 3, 0, 1, 2, 3};
        base_plan[0] = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_F000;
        base_plan[1] = 64'h0;
        base_plan[2] = {$urandom, $urandom};
        base_plan[3] = 64'hFFFF_FFFF_FF00_0000;
        base_plan[4] = {$urandom, $urandom};
        base_plan[5] = 64'h0;
        base_plan[6] = 64'hFFFF_FFFF_FFFF_FC00;
        base_plan[7] = 64'h8000_0000;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: capacity 1024, stride 32, base 0
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_ALLOC, '1, '1);
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_FREE_INDEX, 12'd1, '0);
        issue(dsa_pkg::OP_FREE_INDEX, 12'd1, '1);
        issue(dsa_pkg::OP_FREE_INDEX, 12'hFFF, '0);
        issue(dsa_pkg::OP_FREE_HANDLE, '0, 64'd64);
        issue(dsa_pkg::OP_FREE_HANDLE, '0, 64'd65);
        issue(dsa_pkg::OP_FREE_HANDLE, 12'hFFF, '1);
        // aligned but the quotient is far past capacity
        issue(dsa_pkg::OP_FREE_HANDLE, '0, 64'hFFFF_FFFF_FFFF_FFE0);
        issue(OP_UNDEFINED, '1, '1);
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_FREE_INDEX, 12'd0, '0);
        issue(dsa_pkg::OP_FREE_HANDLE, '0, 64'd0);

        // zero stride, then run the bump pointer into exhaustion
        drain();
        program_registers(11'd5, 13'd0, 64'h100);
        issue(dsa_pkg::OP_FREE_HANDLE, '0, 64'h100);
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_FREE_INDEX, 12'd4, '0);

        // capacity lowered below slots still on the stack or in use
        drain();
        program_registers(11'd2, 13'd4096, 64'hFFFF_FFFF_FFFF_0000);
        issue(dsa_pkg::OP_FREE_HANDLE, '0, 64'h10);
        issue(dsa_pkg::OP_ALLOC, '0, '0);
        issue(dsa_pkg::OP_FREE_INDEX, 12'd4, '0);
        issue(dsa_pkg::OP_FREE_INDEX, 12'd3, '0);
        issue(dsa_pkg::OP_FREE_HANDLE, '0, 64'hFFFF_FFFF_FFFF_1000);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            program_registers(cap_plan[p], stride_plan[p], base_plan[p]);
            sender_idle_pct    = (idle_plan[p] == 1) ? 77 : (idle_plan[p] == 3) ? 19 : 0;
            receiver_stall_pct = (idle_plan[p] == 2) ? 77 : (idle_plan[p] == 3) ? 19 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n == RANDOM_PER_PHASE / 2)
                    drain();
                random_request();
            end
        end

        s_axis_tvalid <= 1'b0;
        receiver_stall_pct = 0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("%0d requests and %0d replies over %0d register settings and four idle patterns",
                 ledger.requests, ledger.replies, PHASES + 3);
        $display("replies: ok %0d, exhausted %0d, out of range %0d, double free %0d, misaligned %0d",
                 ledger.by_status[dsa_pkg::STATUS_OK], ledger.by_status[dsa_pkg::STATUS_EXHAUSTED],
                 ledger.by_status[dsa_pkg::STATUS_RANGE], ledger.by_status[dsa_pkg::STATUS_DOUBLE],
                 ledger.by_status[dsa_pkg::STATUS_MISALIGN]);
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("descriptor_slot_allocator: match");
        else
            $display("descriptor_slot_allocator: mismatch");
        $finish;
    end

endmodule
